>>> rtl/core/wir_pkg.sv
// ----------------------------------------------------------------------------
// wir_pkg: shared types and constants of the workloop ID registry
// Status codes, settings layout, scan token and table write command.
// ----------------------------------------------------------------------------
package wir_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int SLOT_W            = 10;
    localparam int ID_W              = 64;
    localparam int SETTINGS_W        = 43;
    localparam int STATUS_W          = 3;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVAL  = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_EXISTS = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOENT  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 3'd4;

    localparam int FLAG_PRIO_BIT   = 24;
    localparam int FLAG_POLICY_BIT = 26;
    localparam int FLAG_CPU_BIT    = 27;
    localparam int PRIO_MAX        = 63;
    localparam int PCT_MAX         = 100;

    localparam logic MODE_CREATE  = 1'b0;
    localparam logic MODE_DESTROY = 1'b1;

    typedef struct packed {
        logic              active;
        logic              found;
        logic [SLOT_W-1:0] found_slot;
        logic              free_seen;
        logic [SLOT_W-1:0] free_slot;
        logic [ID_W-1:0]   id;
    } wir_tok_t;

    typedef struct packed {
        logic                  we;
        logic                  set_used;
        logic [SLOT_W-1:0]     slot;
        logic [ID_W-1:0]       id;
        logic [SETTINGS_W-1:0] settings;
    } wir_cmd_t;

endpackage

>>> rtl/core/wir_cell.sv
// ----------------------------------------------------------------------------
// wir_cell: one registry slot
// Holds one entry, updates the passing scan token and forwards it.
// ----------------------------------------------------------------------------
module wir_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  wir_pkg::wir_tok_t tok_i,
    output wir_pkg::wir_tok_t tok_o,
    input  wir_pkg::wir_cmd_t cmd_i
);
    import wir_pkg::*;

    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(CELL_IDX);

    logic                  used_reg;
    logic                  used_next;
    logic [ID_W-1:0]       id_reg;
    logic [SETTINGS_W-1:0] settings_reg;
    wir_tok_t              tok_reg;
    wir_tok_t              tok_next;
    logic                  hit;
    logic                  sel;

    assign hit = used_reg && (id_reg == tok_i.id);
    assign sel = cmd_i.we && (cmd_i.slot == MY_SLOT);

    always_comb begin
        tok_next = tok_i;
        if (!tok_i.found && hit) begin
            tok_next.found      = 1'b1;
            tok_next.found_slot = MY_SLOT;
        end
        if (!tok_i.free_seen && !used_reg) begin
            tok_next.free_seen = 1'b1;
            tok_next.free_slot = MY_SLOT;
        end
        used_next = sel ? cmd_i.set_used : used_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= 1'b0;
            tok_reg  <= '0;
        end else begin
            used_reg <= used_next;
            tok_reg  <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (sel && cmd_i.set_used) begin
            id_reg       <= cmd_i.id;
            settings_reg <= cmd_i.settings;
        end
    end

    assign tok_o = tok_reg;

endmodule

>>> rtl/core/workloop_id_registry_core.sv
// A request is registered into the inject register, and the scan token then walks the
// chain of slot cells one cell per cycle; the result is registered at the output.
// A new request is accepted only in ST_IDLE, once the previous result has moved on.
// A finished result waits in the output register while the next request runs.
// Reset: synchronous active-low aresetn empties the table and the pipeline.
// ----------------------------------------------------------------------------
// workloop_id_registry_core: bounded registry of 64-bit workloop IDs
// Checks create/destroy requests, scans the slot chain, commits and reports.
// ----------------------------------------------------------------------------
module workloop_id_registry_core #(
    parameter int TABLE_ENTRIES = wir_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_mode,
    input  logic [wir_pkg::ID_W-1:0]      s_loop_id,
    input  logic                          s_attr_present,
    input  logic [31:0]                   s_attr_flags,
    input  logic [31:0]                   s_cpu_config,
    input  logic signed [31:0]            s_sched_priority,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [wir_pkg::STATUS_W-1:0]  m_status
);
    import wir_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    wir_tok_t              inject_reg;
    wir_tok_t              inject_next;
    wir_tok_t              tok [0:TABLE_ENTRIES];
    wir_cmd_t              cmd;

    logic                  req_mode_reg;
    logic                  req_inval_reg;
    logic [SETTINGS_W-1:0] req_settings_reg;
    logic [STATUS_W-1:0]   hold_status_reg;
    logic [STATUS_W-1:0]   hold_status_next;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic [STATUS_W-1:0]   m_status_reg;
    logic [STATUS_W-1:0]   m_status_next;

    logic                  accept;
    logic                  finish;
    logic [STATUS_W-1:0]   fin_status;

    logic                  id_ok;
    logic                  has_prio;
    logic                  has_pol;
    logic                  has_cpu;
    logic [31:0]           prio_u;
    logic [7:0]            pol;
    logic [7:0]            pct;
    logic [23:0]           refill;
    logic                  attr_ok;
    logic                  in_inval;
    logic [SETTINGS_W-1:0] in_settings;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign finish  = tok[TABLE_ENTRIES].active && (state_reg == ST_SCAN);

    always_comb begin
        id_ok    = (s_loop_id != '0) && (s_loop_id != '1);
        has_prio = s_attr_flags[FLAG_PRIO_BIT];
        has_pol  = s_attr_flags[FLAG_POLICY_BIT];
        has_cpu  = s_attr_flags[FLAG_CPU_BIT];
        prio_u   = $unsigned(s_sched_priority);
        pol      = s_attr_flags[23:16];
        pct      = s_cpu_config[7:0];
        refill   = s_cpu_config[31:8];
        attr_ok  = has_prio || has_pol || has_cpu;
        if (has_prio && ((prio_u < 32'd1) || (prio_u > 32'(PRIO_MAX)))) begin
            attr_ok = 1'b0;
        end
        if (has_pol && !((pol == 8'd1) || (pol == 8'd2) || (pol == 8'd4))) begin
            attr_ok = 1'b0;
        end
        if (has_cpu && ((pct < 8'd1) || (pct > 8'(PCT_MAX)) || (refill == '0))) begin
            attr_ok = 1'b0;
        end
        in_settings = '0;
        if (has_prio) begin
            in_settings[0]   = 1'b1;
            in_settings[6:1] = prio_u[5:0];
        end
        if (has_pol) begin
            in_settings[7]    = 1'b1;
            in_settings[10:8] = pol[2:0];
        end
        if (has_cpu) begin
            in_settings[11]    = 1'b1;
            in_settings[18:12] = pct[6:0];
            in_settings[42:19] = refill;
        end
        if (s_mode == MODE_DESTROY) begin
            in_inval = !id_ok;
        end else begin
            in_inval = !id_ok || !s_attr_present || !attr_ok;
        end
    end

    always_comb begin
        inject_next        = '0;
        inject_next.active = accept;
        inject_next.id     = s_loop_id;
    end

    assign tok[0] = inject_reg;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
            wir_cell #(
                .CELL_IDX (gi)
            ) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .tok_i   (tok[gi]),
                .tok_o   (tok[gi+1]),
                .cmd_i   (cmd)
            );
        end
    endgenerate

    always_comb begin
        cmd          = '0;
        cmd.id       = tok[TABLE_ENTRIES].id;
        cmd.settings = req_settings_reg;
        fin_status   = STATUS_INVAL;
        if (req_inval_reg) begin
            fin_status = STATUS_INVAL;
        end else if (req_mode_reg == MODE_DESTROY) begin
            if (tok[TABLE_ENTRIES].found) begin
                fin_status   = STATUS_OK;
                cmd.we       = finish;
                cmd.set_used = 1'b0;
                cmd.slot     = tok[TABLE_ENTRIES].found_slot;
            end else begin
                fin_status = STATUS_NOENT;
            end
        end else if (tok[TABLE_ENTRIES].found) begin
            fin_status = STATUS_EXISTS;
        end else if (tok[TABLE_ENTRIES].free_seen) begin
            fin_status   = STATUS_OK;
            cmd.we       = finish;
            cmd.set_used = 1'b1;
            cmd.slot     = tok[TABLE_ENTRIES].free_slot;
        end else begin
            fin_status = STATUS_FULL;
        end
    end

    always_comb begin
        state_next       = state_reg;
        hold_status_next = hold_status_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_status_next    = m_status_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (finish) begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_next  = 1'b1;
                        m_status_next = fin_status;
                        state_next    = ST_IDLE;
                    end else begin
                        hold_status_next = fin_status;
                        state_next       = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = hold_status_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            inject_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            inject_reg  <= inject_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_status_reg <= hold_status_next;
        m_status_reg    <= m_status_next;
        if (accept) begin
            req_mode_reg     <= s_mode;
            req_inval_reg    <= in_inval;
            req_settings_reg <= in_settings;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;

`ifndef SYNTH
    a_exit_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        tok[TABLE_ENTRIES].active |-> (state_reg == ST_SCAN))
        else $error("scan token left the chain outside a scan");
    a_inject: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> tok[0].active)
        else $error("accepted transaction did not start a scan");
    a_write_at_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.we |-> (finish && !req_inval_reg))
        else $error("table written outside a valid finish");
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HOLD) |-> m_valid_reg)
        else $error("result held while output register empty");
`endif

endmodule
